[hdl/gradient_noise_3d_top_assert.svh]
// assertion macros shared by the noise block
`ifndef GRADIENT_NOISE_3D_TOP_ASSERT_SVH
`define GRADIENT_NOISE_3D_TOP_ASSERT_SVH

// property must hold on every clock edge outside reset
`define GN_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent on the next edge
`define GN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/gn3_pkg.sv]
`default_nettype none
package gn3_pkg;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // request carried from front to back
    typedef struct packed {
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] cz;
        logic [23:0] fx;
        logic [23:0] fy;
        logic [23:0] fz;
    } t_cell_req;

    function automatic logic [7:0] perm(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'd0: r=8'd151; 8'd1: r=8'd160; 8'd2: r=8'd137; 8'd3: r=8'd91;
            8'd4: r=8'd90; 8'd5: r=8'd15; 8'd6: r=8'd131; 8'd7: r=8'd13;
            8'd8: r=8'd201; 8'd9: r=8'd95; 8'd10: r=8'd96; 8'd11: r=8'd53;
            8'd12: r=8'd194; 8'd13: r=8'd233; 8'd14: r=8'd7; 8'd15: r=8'd225;
            8'd16: r=8'd140; 8'd17: r=8'd36; 8'd18: r=8'd103; 8'd19: r=8'd30;
            8'd20: r=8'd69; 8'd21: r=8'd142; 8'd22: r=8'd8; 8'd23: r=8'd99;
            8'd24: r=8'd37; 8'd25: r=8'd240; 8'd26: r=8'd21; 8'd27: r=8'd10;
            8'd28: r=8'd23; 8'd29: r=8'd190; 8'd30: r=8'd6; 8'd31: r=8'd148;
            8'd32: r=8'd247; 8'd33: r=8'd120; 8'd34: r=8'd234; 8'd35: r=8'd75;
            8'd36: r=8'd0; 8'd37: r=8'd26; 8'd38: r=8'd197; 8'd39: r=8'd62;
            8'd40: r=8'd94; 8'd41: r=8'd252; 8'd42: r=8'd219; 8'd43: r=8'd203;
            8'd44: r=8'd117; 8'd45: r=8'd35; 8'd46: r=8'd11; 8'd47: r=8'd32;
            8'd48: r=8'd57; 8'd49: r=8'd177; 8'd50: r=8'd33; 8'd51: r=8'd88;
            8'd52: r=8'd237; 8'd53: r=8'd149; 8'd54: r=8'd56; 8'd55: r=8'd87;
            8'd56: r=8'd174; 8'd57: r=8'd20; 8'd58: r=8'd125; 8'd59: r=8'd136;
            8'd60: r=8'd171; 8'd61: r=8'd168; 8'd62: r=8'd68; 8'd63: r=8'd175;
            8'd64: r=8'd74; 8'd65: r=8'd165; 8'd66: r=8'd71; 8'd67: r=8'd134;
            8'd68: r=8'd139; 8'd69: r=8'd48; 8'd70: r=8'd27; 8'd71: r=8'd166;
            8'd72: r=8'd77; 8'd73: r=8'd146; 8'd74: r=8'd158; 8'd75: r=8'd231;
            8'd76: r=8'd83; 8'd77: r=8'd111; 8'd78: r=8'd229; 8'd79: r=8'd122;
            8'd80: r=8'd60; 8'd81: r=8'd211; 8'd82: r=8'd133; 8'd83: r=8'd230;
            8'd84: r=8'd220; 8'd85: r=8'd105; 8'd86: r=8'd92; 8'd87: r=8'd41;
            8'd88: r=8'd55; 8'd89: r=8'd46; 8'd90: r=8'd245; 8'd91: r=8'd40;
            8'd92: r=8'd244; 8'd93: r=8'd102; 8'd94: r=8'd143; 8'd95: r=8'd54;
            8'd96: r=8'd65; 8'd97: r=8'd25; 8'd98: r=8'd63; 8'd99: r=8'd161;
            8'd100: r=8'd1; 8'd101: r=8'd216; 8'd102: r=8'd80; 8'd103: r=8'd73;
            8'd104: r=8'd209; 8'd105: r=8'd76; 8'd106: r=8'd132; 8'd107: r=8'd187;
            8'd108: r=8'd208; 8'd109: r=8'd89; 8'd110: r=8'd18; 8'd111: r=8'd169;
            8'd112: r=8'd200; 8'd113: r=8'd196; 8'd114: r=8'd135; 8'd115: r=8'd130;
            8'd116: r=8'd116; 8'd117: r=8'd188; 8'd118: r=8'd159; 8'd119: r=8'd86;
            8'd120: r=8'd164; 8'd121: r=8'd100; 8'd122: r=8'd109; 8'd123: r=8'd198;
            8'd124: r=8'd173; 8'd125: r=8'd186; 8'd126: r=8'd3; 8'd127: r=8'd64;
            8'd128: r=8'd52; 8'd129: r=8'd217; 8'd130: r=8'd226; 8'd131: r=8'd250;
            8'd132: r=8'd124; 8'd133: r=8'd123; 8'd134: r=8'd5; 8'd135: r=8'd202;
            8'd136: r=8'd38; 8'd137: r=8'd147; 8'd138: r=8'd118; 8'd139: r=8'd126;
            8'd140: r=8'd255; 8'd141: r=8'd82; 8'd142: r=8'd85; 8'd143: r=8'd212;
            8'd144: r=8'd207; 8'd145: r=8'd206; 8'd146: r=8'd59; 8'd147: r=8'd227;
            8'd148: r=8'd47; 8'd149: r=8'd16; 8'd150: r=8'd58; 8'd151: r=8'd17;
            8'd152: r=8'd182; 8'd153: r=8'd189; 8'd154: r=8'd28; 8'd155: r=8'd42;
            8'd156: r=8'd223; 8'd157: r=8'd183; 8'd158: r=8'd170; 8'd159: r=8'd213;
            8'd160: r=8'd119; 8'd161: r=8'd248; 8'd162: r=8'd152; 8'd163: r=8'd2;
            8'd164: r=8'd44; 8'd165: r=8'd154; 8'd166: r=8'd163; 8'd167: r=8'd70;
            8'd168: r=8'd221; 8'd169: r=8'd153; 8'd170: r=8'd101; 8'd171: r=8'd155;
            8'd172: r=8'd167; 8'd173: r=8'd43; 8'd174: r=8'd172; 8'd175: r=8'd9;
            8'd176: r=8'd129; 8'd177: r=8'd22; 8'd178: r=8'd39; 8'd179: r=8'd253;
            8'd180: r=8'd19; 8'd181: r=8'd98; 8'd182: r=8'd108; 8'd183: r=8'd110;
            8'd184: r=8'd79; 8'd185: r=8'd113; 8'd186: r=8'd224; 8'd187: r=8'd232;
            8'd188: r=8'd178; 8'd189: r=8'd185; 8'd190: r=8'd112; 8'd191: r=8'd104;
            8'd192: r=8'd218; 8'd193: r=8'd246; 8'd194: r=8'd97; 8'd195: r=8'd228;
            8'd196: r=8'd251; 8'd197: r=8'd34; 8'd198: r=8'd242; 8'd199: r=8'd193;
            8'd200: r=8'd238; 8'd201: r=8'd210; 8'd202: r=8'd144; 8'd203: r=8'd12;
            8'd204: r=8'd191; 8'd205: r=8'd179; 8'd206: r=8'd162; 8'd207: r=8'd241;
            8'd208: r=8'd81; 8'd209: r=8'd51; 8'd210: r=8'd145; 8'd211: r=8'd235;
            8'd212: r=8'd249; 8'd213: r=8'd14; 8'd214: r=8'd239; 8'd215: r=8'd107;
            8'd216: r=8'd49; 8'd217: r=8'd192; 8'd218: r=8'd214; 8'd219: r=8'd31;
            8'd220: r=8'd181; 8'd221: r=8'd199; 8'd222: r=8'd106; 8'd223: r=8'd157;
            8'd224: r=8'd184; 8'd225: r=8'd84; 8'd226: r=8'd204; 8'd227: r=8'd176;
            8'd228: r=8'd115; 8'd229: r=8'd121; 8'd230: r=8'd50; 8'd231: r=8'd45;
            8'd232: r=8'd127; 8'd233: r=8'd4; 8'd234: r=8'd150; 8'd235: r=8'd254;
            8'd236: r=8'd138; 8'd237: r=8'd236; 8'd238: r=8'd205; 8'd239: r=8'd93;
            8'd240: r=8'd222; 8'd241: r=8'd114; 8'd242: r=8'd67; 8'd243: r=8'd29;
            8'd244: r=8'd24; 8'd245: r=8'd72; 8'd246: r=8'd243; 8'd247: r=8'd141;
            8'd248: r=8'd128; 8'd249: r=8'd195; 8'd250: r=8'd78; 8'd251: r=8'd66;
            8'd252: r=8'd215; 8'd253: r=8'd61; 8'd254: r=8'd156; default: r=8'd180;
        endcase
        return r;
    endfunction

    // hash mod 12 via reciprocal multiply, exact for all 8-bit hashes
    function automatic logic [3:0] mod12(input logic [7:0] h);
        logic [15:0] pr;
        logic [7:0]  q;
        pr = 16'(h) * 16'd171;
        q  = 8'(pr >> 11);
        return 4'(h - 8'(q * 8'd12));
    endfunction
endpackage
`default_nettype wire

[hdl/gn3_queue.sv]
`default_nettype none
module gn3_queue
    import gn3_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_cell_req i_data,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_cell_req      o_data
);
    t_cell_req r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/gn3_front.sv]
`default_nettype none
module gn3_front
    import gn3_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)(
    input  wire logic [31:0] i_x,
    input  wire logic [31:0] i_y,
    input  wire logic [31:0] i_z,
    output t_cell_req        o_req
);
    // split into cell index and fraction
    always_comb begin
        o_req = '0;
        o_req.cx = i_x[COORD_FRAC_BITS +: 8];
        o_req.cy = i_y[COORD_FRAC_BITS +: 8];
        o_req.cz = i_z[COORD_FRAC_BITS +: 8];
        o_req.fx[COORD_FRAC_BITS-1:0] = i_x[COORD_FRAC_BITS-1:0];
        o_req.fy[COORD_FRAC_BITS-1:0] = i_y[COORD_FRAC_BITS-1:0];
        o_req.fz[COORD_FRAC_BITS-1:0] = i_z[COORD_FRAC_BITS-1:0];
    end
endmodule
`default_nettype wire

[hdl/gn3_back.sv]
`default_nettype none
module gn3_back
    import gn3_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 14
)(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_cell_req i_req,
    output logic           o_ready,
    output logic           o_valid,
    output logic [15:0]    o_value,
    input  wire logic      i_ready
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int W  = F + 4;        // signed corner values and lerp results
    localparam int NS = 9;            // pipeline stages
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    localparam int SH_UP = (RESULT_FRAC_BITS >= F) ? RESULT_FRAC_BITS - F : 0;
    localparam int SH_DN = (RESULT_FRAC_BITS >= F) ? 0 : F - RESULT_FRAC_BITS;

    logic [NS-1:0] r_vld;
    logic          adv;
    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS-1];

    // valid pipeline, stalls as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[NS-2:0], i_valid};
    end

    // stage 1: first hash level (z and z+1)
    logic [7:0] r1_hz [2];
    t_cell_req  r1_q;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_hz[0] <= perm(i_req.cz);
            r1_hz[1] <= perm(i_req.cz + 8'd1);
            r1_q     <= i_req;
        end
    end

    // stage 2: second hash level
    logic [7:0] r2_hy [4];
    t_cell_req  r2_q;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++)
                r2_hy[k] <= perm(r1_q.cy + 8'(k & 1) + r1_hz[k>>1]);
            r2_q <= r1_q;
        end
    end

    // stage 3: final hash level and gradient index
    logic [3:0] r3_g [8];
    t_cell_req  r3_q;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 8; k++)
                r3_g[k] <= mod12(perm(r2_q.cx + 8'(k & 1) + r2_hy[k>>1]));
            r3_q <= r2_q;
        end
    end

    // stage 4: corner dot products and fade squares
    logic signed [W-1:0] r4_n [8];
    logic [F-1:0] r4_t [3];
    logic [F-1:0] r4_t2 [3];
    always_ff @(posedge i_clk) begin
        logic signed [W-1:0] ox, oy, oz, gx, gy, gz;
        logic [2*F-1:0] sq;
        if (adv) begin
            for (int k = 0; k < 8; k++) begin
                ox = W'($signed({1'b0, r3_q.fx[F-1:0]})) - ((k & 1) != 0 ? W'(ONE) : '0);
                oy = W'($signed({1'b0, r3_q.fy[F-1:0]})) - ((k & 2) != 0 ? W'(ONE) : '0);
                oz = W'($signed({1'b0, r3_q.fz[F-1:0]})) - ((k & 4) != 0 ? W'(ONE) : '0);
                case (r3_g[k])
                    4'd0: begin gx = ox;  gy = oy;  gz = '0;  end
                    4'd1: begin gx = -ox; gy = oy;  gz = '0;  end
                    4'd2: begin gx = ox;  gy = -oy; gz = '0;  end
                    4'd3: begin gx = -ox; gy = -oy; gz = '0;  end
                    4'd4: begin gx = ox;  gy = '0;  gz = oz;  end
                    4'd5: begin gx = -ox; gy = '0;  gz = oz;  end
                    4'd6: begin gx = ox;  gy = '0;  gz = -oz; end
                    4'd7: begin gx = -ox; gy = '0;  gz = -oz; end
                    4'd8: begin gx = '0;  gy = oy;  gz = oz;  end
                    4'd9: begin gx = '0;  gy = -oy; gz = oz;  end
                    4'd10: begin gx = '0; gy = oy;  gz = -oz; end
                    default: begin gx = '0; gy = -oy; gz = -oz; end
                endcase
                r4_n[k] <= gx + gy + gz;
            end
            r4_t[0] <= r3_q.fx[F-1:0];
            r4_t[1] <= r3_q.fy[F-1:0];
            r4_t[2] <= r3_q.fz[F-1:0];
            for (int a = 0; a < 3; a++) begin
                case (a)
                    0: sq = r3_q.fx[F-1:0] * r3_q.fx[F-1:0];
                    1: sq = r3_q.fy[F-1:0] * r3_q.fy[F-1:0];
                    default: sq = r3_q.fz[F-1:0] * r3_q.fz[F-1:0];
                endcase
                r4_t2[a] <= sq[2*F-1:F];
            end
        end
    end

    // stage 5: cube and polynomial
    logic signed [W-1:0] r5_n [8];
    logic [F-1:0] r5_t3 [3];
    logic [F+3:0] r5_p [3];
    always_ff @(posedge i_clk) begin
        logic [2*F-1:0] cu;
        if (adv) begin
            r5_n <= r4_n;
            for (int a = 0; a < 3; a++) begin
                cu = r4_t2[a] * r4_t[a];
                r5_t3[a] <= cu[2*F-1:F];
                r5_p[a]  <= (F+4)'(6 * r4_t2[a]) - (F+4)'(15 * r4_t[a])
                          + (F+4)'(10 * ONE);
            end
        end
    end

    // stage 6: fade weight
    logic signed [W-1:0] r6_n [8];
    logic [F:0] r6_w [3];
    always_ff @(posedge i_clk) begin
        logic [2*F+3:0] fp;
        if (adv) begin
            r6_n <= r5_n;
            for (int a = 0; a < 3; a++) begin
                fp = r5_t3[a] * r5_p[a];
                r6_w[a] <= fp[2*F:F];
            end
        end
    end

    // lerp helper product, floor shift
    function automatic logic signed [W-1:0] lerp(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic [F:0] w);
        logic signed [W+F+2:0] pr;
        pr = (W+F+3)'(b - a) * $signed({2'b0, w});
        return a + W'(pr >>> F);
    endfunction

    // stage 7: blend along x
    logic signed [W-1:0] r7_x [4];
    logic [F:0] r7_wy, r7_wz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++)
                r7_x[k] <= lerp(r6_n[2*k], r6_n[2*k+1], r6_w[0]);
            r7_wy <= r6_w[1];
            r7_wz <= r6_w[2];
        end
    end

    // stage 8: blend along y
    logic signed [W-1:0] r8_y [2];
    logic [F:0] r8_wz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_y[0] <= lerp(r7_x[0], r7_x[1], r7_wy);
            r8_y[1] <= lerp(r7_x[2], r7_x[3], r7_wy);
            r8_wz   <= r7_wz;
        end
    end

    // stage 9: blend along z, rescale and saturate
    logic [15:0] r9_v;
    always_ff @(posedge i_clk) begin
        logic signed [W+23:0] v;
        if (adv) begin
            v = (W+24)'(lerp(r8_y[0], r8_y[1], r8_wz));
            v = v <<< SH_UP;
            v = v >>> SH_DN;
            if (v > 32767) r9_v <= 16'h7fff;
            else if (v < -32768) r9_v <= 16'h8000;
            else r9_v <= v[15:0];
        end
    end
    assign o_value = r9_v;

`include "gradient_noise_3d_top_assert.svh"
    `GN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_value))
    `GN_ASSERT_NEXT(a_adv, i_clk, i_rst_n, adv && i_valid, r_vld[0])
    `GN_ASSERT_ALWAYS(a_ready, i_clk, i_rst_n, o_ready == (!o_valid || i_ready))
endmodule
`default_nettype wire

[hdl/gradient_noise_3d_top.sv]
`default_nettype none
// Improved 3D gradient noise: one signed Q16.16 point in, one saturated signed
// Q2.14 noise value out, one point a cycle sustained while i_ready stays high.
// Each request is queued at acceptance and then passes in order through the nine
// pipeline stages (three hash levels, dot products with the fade square, fade cube,
// fade weight, three blend levels).
// For 2D noise drive z with zero.
module gradient_noise_3d_top
    import gn3_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 14
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_coord_x,
    input  wire logic [31:0] i_coord_y,
    input  wire logic [31:0] i_coord_z,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_noise_value
);
    t_cell_req req, qd;
    logic full, empty, bk_ready;

    gn3_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
        .i_x(i_coord_x), .i_y(i_coord_y), .i_z(i_coord_z), .o_req(req)
    );

    assign o_ready = !full;

    gn3_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid && !full), .i_data(req), .o_full(full),
        .i_pop(!empty && bk_ready), .o_empty(empty), .o_data(qd)
    );

    gn3_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS),
               .RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!empty), .i_req(qd), .o_ready(bk_ready),
        .o_valid(o_valid), .o_value(o_noise_value), .i_ready(i_ready)
    );
endmodule
`default_nettype wire
